// ----- src/tshi_pkg.sv -----
// Shared constants and types for the timestamped sample history interpolator.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package tshi_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int TIME_W    = 63;
	localparam int COMP_W    = 16;
	localparam int NCOMP     = 4;
	localparam int SAMP_W    = NCOMP * COMP_W;
	localparam int MEM_W     = TIME_W + SAMP_W;
	localparam int FRAC_W    = 16;
	localparam int CI_W      = $clog2(NCOMP);
	localparam int DIV_CNT_W = $clog2(FRAC_W);

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// identity rotation: w = 1.0 in Q2.14, x = y = z = 0
	localparam logic [COMP_W-1:0] ONE_Q14  = COMP_W'(16384);
	localparam logic [SAMP_W-1:0] IDENTITY = {ONE_Q14, {(SAMP_W - COMP_W){1'b0}}};

	localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
	localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W - 1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_PREP = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

// ----- src/timestamped_sample_history_interpolator_top.sv -----
// Timestamped sample history ring with linear interpolation on query.
// Depends on tshi_pkg; holds the sample/stamp memory and the sequencer.
//
//  channel | signals                                         | dir | transfer
//  --------+-------------------------------------------------+-----+------------------------
//  in      | in_valid in_ready mode time_ns sample_x..w      | in  | in_valid & in_ready
//  out     | out_valid out_ready out_x..w ring_full          | out | out_valid & out_ready
//          | newest_time was_interpolated                    |     |
//
// Append, or query before the ring is full: the result is registered at accept and then
// moved to the output registers in ST_DONE. Query on a full ring: scan reads one entry a
// cycle from the single memory read port, then 1 setup step, 16 restoring-division steps
// on one subtractor and 4 steps of one shared multiplier (one component each), then ST_DONE.
// Reset clears the control state, pointers, counts and newest time; the memory is not cleared.
// in_ready is high only while the sequencer idles; a stalled output holds the next
// result in a staging register, so one transaction may be accepted behind it.
`timescale 1ns / 1ps

module timestamped_sample_history_interpolator_top
	import tshi_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [TIME_W-1:0]        time_ns,
	input  logic signed [COMP_W-1:0] sample_x,
	input  logic signed [COMP_W-1:0] sample_y,
	input  logic signed [COMP_W-1:0] sample_z,
	input  logic signed [COMP_W-1:0] sample_w,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [COMP_W-1:0] out_x,
	output logic signed [COMP_W-1:0] out_y,
	output logic signed [COMP_W-1:0] out_z,
	output logic signed [COMP_W-1:0] out_w,
	output logic                     ring_full,
	output logic [TIME_W-1:0]        newest_time,
	output logic                     was_interpolated
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] LAST_CNT  = CW'(DEPTH - 1);
	localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(FRAC_W - 1);
	localparam logic [CI_W-1:0] LAST_CI = CI_W'(NCOMP - 1);

	// storage
	logic [MEM_W-1:0] mem_q [DEPTH];
	logic [MEM_W-1:0] rd_q;
	logic [AW-1:0]    rd_addr;

	// control
	state_t          state_q;
	logic            out_valid_q;
	logic [AW-1:0]   write_slot_q;
	logic [CW-1:0]   fill_cnt_q;
	logic [AW-1:0]   scan_addr_q;
	logic [CW-1:0]   issue_cnt_q;
	logic [CW-1:0]   chk_cnt_q;
	logic            rd_vld_q;
	logic            have_lo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CI_W-1:0] ci_q;

	// datapath
	logic [TIME_W-1:0] newest_time_q;
	logic [SAMP_W-1:0] newest_samp_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] lo_time_q;
	logic [SAMP_W-1:0] lo_samp_q;
	logic [TIME_W-1:0] hi_time_q;
	logic [SAMP_W-1:0] hi_samp_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [FRAC_W-1:0] frac_q;
	logic [SAMP_W-1:0] res_samp_q;
	logic [TIME_W-1:0] res_time_q;
	logic              res_full_q;
	logic              res_interp_q;
	logic [SAMP_W-1:0] out_samp_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_full_q;
	logic              out_interp_q;

	logic              accept_in;
	logic              out_free;
	logic [TIME_W-1:0] rd_time;
	logic [SAMP_W-1:0] rd_samp;
	logic              le_hit;
	logic [TIME_W:0]   rem_sh;
	logic              rem_ge;
	logic [SAMP_W-1:0] in_samp;
	logic [AW-1:0]     scan_addr_nxt;
	logic [AW-1:0]     write_slot_nxt;

	logic signed [COMP_W-1:0]   comp_a;
	logic signed [COMP_W-1:0]   comp_b;
	logic signed [COMP_W:0]     comp_diff;
	logic signed [2*COMP_W+1:0] comp_prod;
	logic signed [COMP_W+1:0]   comp_step;
	logic signed [COMP_W+2:0]   comp_sum;
	logic signed [COMP_W-1:0]   comp_sat;

	assign accept_in = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign in_samp   = {sample_w, sample_z, sample_y, sample_x};

	assign rd_time = rd_q[MEM_W-1 -: TIME_W];
	assign rd_samp = rd_q[SAMP_W-1:0];
	assign le_hit  = (rd_time <= t_q);
	assign rd_addr = scan_addr_q;

	assign scan_addr_nxt  = (scan_addr_q == LAST_SLOT) ? '0 : scan_addr_q + 1'b1;
	assign write_slot_nxt = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;

	// restoring division step; rem stays below den, so the shift never overflows
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	// shared interpolation unit: a + floor(f * (b - a) / 2^16), one component a cycle
	assign comp_a    = lo_samp_q[ci_q*COMP_W +: COMP_W];
	assign comp_b    = hi_samp_q[ci_q*COMP_W +: COMP_W];
	assign comp_diff = {comp_b[COMP_W-1], comp_b} - {comp_a[COMP_W-1], comp_a};
	assign comp_prod = $signed({1'b0, frac_q}) * comp_diff;
	assign comp_step = comp_prod[2*COMP_W+1 -: (COMP_W + 2)];
	assign comp_sum  = {{3{comp_a[COMP_W-1]}}, comp_a} + {comp_step[COMP_W+1], comp_step};

	always_comb begin
		if (comp_sum > $signed({{3{1'b0}}, COMP_MAX})) begin
			comp_sat = COMP_MAX;
		end else if (comp_sum < $signed({{3{1'b1}}, COMP_MIN})) begin
			comp_sat = COMP_MIN;
		end else begin
			comp_sat = comp_sum[COMP_W-1:0];
		end
	end

	// memory: one write port on an accepted append, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (accept_in && mode == MODE_APPEND) begin
			mem_q[write_slot_q] <= {time_ns, in_samp};
		end
		rd_q <= mem_q[rd_addr];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			write_slot_q  <= '0;
			fill_cnt_q    <= '0;
			newest_time_q <= '0;
			scan_addr_q   <= '0;
			issue_cnt_q   <= '0;
			chk_cnt_q     <= '0;
			rd_vld_q      <= 1'b0;
			have_lo_q     <= 1'b0;
			div_cnt_q     <= '0;
			ci_q          <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						if (mode == MODE_APPEND) begin
							write_slot_q  <= write_slot_nxt;
							newest_time_q <= time_ns;
							if (fill_cnt_q != DEPTH_CNT) begin
								fill_cnt_q <= fill_cnt_q + 1'b1;
							end
							state_q <= ST_DONE;
						end else if (fill_cnt_q != DEPTH_CNT) begin
							state_q <= ST_DONE;
						end else begin
							scan_addr_q <= write_slot_q;
							issue_cnt_q <= '0;
							chk_cnt_q   <= '0;
							rd_vld_q    <= 1'b0;
							have_lo_q   <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_q <= (issue_cnt_q != DEPTH_CNT);
					if (issue_cnt_q != DEPTH_CNT) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
						scan_addr_q <= scan_addr_nxt;
					end
					if (rd_vld_q) begin
						chk_cnt_q <= chk_cnt_q + 1'b1;
						if (le_hit) begin
							have_lo_q <= 1'b1;
							if (chk_cnt_q == LAST_CNT) begin
								state_q <= ST_DONE;
							end
						end else if (have_lo_q && lo_time_q != '0) begin
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == LAST_DIV) begin
						ci_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					ci_q <= ci_q + 1'b1;
					if (ci_q == LAST_CI) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					t_q <= time_ns;
					if (mode == MODE_APPEND) begin
						newest_samp_q <= in_samp;
						res_samp_q    <= in_samp;
						res_time_q    <= time_ns;
						res_full_q    <= (fill_cnt_q >= LAST_CNT);
						res_interp_q  <= 1'b0;
					end else begin
						res_time_q   <= newest_time_q;
						res_full_q   <= (fill_cnt_q == DEPTH_CNT);
						res_interp_q <= 1'b0;
						res_samp_q   <= (fill_cnt_q == DEPTH_CNT) ? newest_samp_q : IDENTITY;
					end
				end
			end
			ST_SCAN: begin
				if (rd_vld_q) begin
					if (le_hit) begin
						lo_time_q <= rd_time;
						lo_samp_q <= rd_samp;
					end else begin
						hi_time_q <= rd_time;
						hi_samp_q <= rd_samp;
					end
				end
			end
			ST_PREP: begin
				rem_q <= t_q - lo_time_q;
				den_q <= hi_time_q - lo_time_q;
			end
			ST_DIV: begin
				rem_q  <= TIME_W'(rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh);
				frac_q <= {frac_q[FRAC_W-2:0], rem_ge};
			end
			ST_MUL: begin
				res_samp_q[ci_q*COMP_W +: COMP_W] <= comp_sat;
				res_interp_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_samp_q   <= res_samp_q;
					out_time_q   <= res_time_q;
					out_full_q   <= res_full_q;
					out_interp_q <= res_interp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign out_x            = out_samp_q[0*COMP_W +: COMP_W];
	assign out_y            = out_samp_q[1*COMP_W +: COMP_W];
	assign out_z            = out_samp_q[2*COMP_W +: COMP_W];
	assign out_w            = out_samp_q[3*COMP_W +: COMP_W];
	assign ring_full        = out_full_q;
	assign newest_time      = out_time_q;
	assign was_interpolated = out_interp_q;

endmodule

// ----- src/tshi_checker.sv -----
// Port-level checks for the sample history interpolator, bound to its top level.
// Depends on tshi_pkg and timestamped_sample_history_interpolator_top.
`timescale 1ns / 1ps

module tshi_checker
	import tshi_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     mode,
	input logic [TIME_W-1:0]        time_ns,
	input logic signed [COMP_W-1:0] sample_x,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [COMP_W-1:0] out_x,
	input logic                     ring_full,
	input logic [TIME_W-1:0]        newest_time,
	input logic                     was_interpolated
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(newest_time))
		else $error("output changed while stalled");

	// one transaction in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// an append into a free output shows its echo through the result and output registers
	a_append_echo: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_APPEND && !out_valid |-> ##2
		(out_valid && out_x == $past(sample_x, 2) && newest_time == $past(time_ns, 2)
		&& !was_interpolated))
		else $error("append echo mismatch");

	// interpolation only happens on a full ring
	a_interp_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_interpolated |-> ring_full)
		else $error("interpolated result on a partial ring");

endmodule

bind timestamped_sample_history_interpolator_top tshi_checker u_tshi_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.mode             (mode),
	.time_ns          (time_ns),
	.sample_x         (sample_x),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.out_x            (out_x),
	.ring_full        (ring_full),
	.newest_time      (newest_time),
	.was_interpolated (was_interpolated)
);
